// File: hdl/wavetable_lfo_gain_modulator_core_assert.svh
// Assertion helpers for the checker file of this block.
// WLGM_ASSERT expects signals named clk and arst_n, WLGM_ASSERT_ALWAYS only clk, in the scope where used.
`ifndef WAVETABLE_LFO_GAIN_MODULATOR_CORE_ASSERT_SVH
`define WAVETABLE_LFO_GAIN_MODULATOR_CORE_ASSERT_SVH

// Checked only while the block is out of reset.
`define WLGM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define WLGM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/wlgm_pkg.sv
package wlgm_pkg;

	// Wavetable geometry.
	localparam int TABLE_DEPTH = 2048;
	localparam int TBL_AW      = $clog2(TABLE_DEPTH);

	// Field widths.
	localparam int SMP_W   = 24;
	localparam int Q16_W   = 17;
	localparam int PHASE_W = 32;
	localparam int CFG_W   = 32;
	localparam int CFG_AW  = 3;

	// Fixed-point constants.
	localparam logic [Q16_W-1:0] ONE_Q16  = 17'd65536;
	localparam logic [Q16_W-1:0] HALF_Q16 = 17'd32768;

	// Operation codes carried by an input item.
	localparam logic [1:0] OP_PROCESS   = 2'd0;
	localparam logic [1:0] OP_WRITE     = 2'd1;
	localparam logic [1:0] OP_SET_PHASE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_AW-1:0] REG_MOD_TARGET   = 3'd0;
	localparam logic [CFG_AW-1:0] REG_PHASE_STEP   = 3'd1;
	localparam logic [CFG_AW-1:0] REG_PHASE_OFFSET = 3'd2;
	localparam logic [CFG_AW-1:0] REG_MOD_DEPTH    = 3'd3;
	localparam logic [CFG_AW-1:0] REG_INVERT_WAVE  = 3'd4;
	localparam logic [CFG_AW-1:0] REG_GLIDE_COEFF  = 3'd5;
	localparam logic [CFG_AW-1:0] REG_WET_GAIN     = 3'd6;
	localparam logic [CFG_AW-1:0] REG_DRY_GAIN     = 3'd7;

	// Register values after reset.
	localparam logic [PHASE_W-1:0] RST_PHASE_STEP  = 32'd89478;
	localparam logic [15:0]        RST_GLIDE_COEFF = 16'd64000;

	typedef struct packed {
		logic [1:0]              operation;
		logic signed [SMP_W-1:0] left_in;
		logic signed [SMP_W-1:0] right_in;
		logic [10:0]             table_index;
		logic [Q16_W-1:0]        table_value;
		logic [PHASE_W-1:0]      phase_value;
	} wlgm_in_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] left_out;
		logic signed [SMP_W-1:0] right_out;
		logic [Q16_W-1:0]        mod_value;
		logic [PHASE_W-1:0]      phase_out;
	} wlgm_out_t;

endpackage

// File: hdl/wlgm_if.sv
// Item channel towards the block.
interface wlgm_in_if import wlgm_pkg::*; ();
	logic     valid;
	logic     ready;
	wlgm_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Item channel out of the block.
interface wlgm_out_if import wlgm_pkg::*; ();
	logic      valid;
	logic      ready;
	wlgm_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/wlgm_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module wlgm_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write first in program order; a same-address read returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/wavetable_lfo_gain_modulator_core.sv
// Stereo gain / width modulator driven by a wavetable oscillator.
// Channels: items (sink) takes input items, results (source) gives result items;
// both move an item when valid and ready are high at a rising edge of clk.
// Configuration: cfg_we, cfg_index and cfg_wdata write one register per cycle;
// the user must write only while the block is idle; the block does not enforce it.
// A process item is taken, then runs through an eight-step sequencer (table
// address, second table read, interpolation, depth, glide, three mixing steps);
// its result is loaded into the output register as the last step ends, after
// which the block returns to idle; no new item is taken while it is in flight.
// The sequencing is set by the two reads through the single read port of the
// wavetable RAM and the chain of multiplications that each depend on the previous one.
// Table writes, phase sets and unknown operations are taken while idle and give no result.
// A finished result waits in the output register; the block meanwhile takes
// the next item, and only a process item that finishes while the previous
// result is still untaken waits in its last step.
// Reset clears the oscillator phase, sets the glide state to the neutral value
// and loads the register defaults; the wavetable is not cleared and must be
// written before it is read.
module wavetable_lfo_gain_modulator_core import wlgm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	wlgm_in_if.sink           items,
	wlgm_out_if.source        results
);

	// Sequencer states.
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_ADDR   = 4'd1;
	localparam logic [3:0] ST_RD1    = 4'd2;
	localparam logic [3:0] ST_INTERP = 4'd3;
	localparam logic [3:0] ST_DEPTH  = 4'd4;
	localparam logic [3:0] ST_GLIDE  = 4'd5;
	localparam logic [3:0] ST_MIX1   = 4'd6;
	localparam logic [3:0] ST_MIX2   = 4'd7;
	localparam logic [3:0] ST_MIX3   = 4'd8;

	localparam int PD_W = PHASE_W + TBL_AW;

	function automatic logic [Q16_W-1:0] clamp_one(input logic [Q16_W-1:0] v);
		clamp_one = (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

	// Sum of the partial products of one lane, rounded by 2^32 and saturated.
	function automatic logic signed [SMP_W-1:0] mix_lane(
		input logic signed [42:0] p_hi,
		input logic signed [42:0] p_lo,
		input logic signed [42:0] mid,
		input logic signed [41:0] dry,
		input logic               use_mid
	);
		logic signed [61:0] acc;
		logic signed [29:0] q;
		acc = (62'(p_hi) <<< 17) + 62'(p_lo) + (62'(dry) <<< 16) + 62'sd2147483648;
		if (use_mid) begin
			acc = acc + (62'(mid) <<< 15);
		end
		q = acc[61:32];
		if (q > 30'sd8388607) begin
			mix_lane = 24'sh7FFFFF;
		end else if (q < -30'sd8388608) begin
			mix_lane = -24'sd8388608;
		end else begin
			mix_lane = q[SMP_W-1:0];
		end
	endfunction

	// Control and configuration state.
	logic [3:0]         state_q;
	logic               mod_target_q;
	logic [PHASE_W-1:0] phase_step_q;
	logic [PHASE_W-1:0] phase_offset_q;
	logic [Q16_W-1:0]   mod_depth_q;
	logic               invert_q;
	logic [15:0]        glide_q;
	logic [Q16_W-1:0]   wet_q;
	logic [Q16_W-1:0]   dry_q;
	logic [PHASE_W-1:0] phase_q;
	logic [Q16_W-1:0]   smoothed_q;
	logic               out_valid_q;

	// Datapath registers.
	logic signed [SMP_W-1:0] l_q, r_q;
	logic [PHASE_W-1:0]      pos_q;
	logic [TBL_AW-1:0]       i1_q;
	logic [15:0]             frac_q;
	logic [Q16_W-1:0]        t0_q;
	logic [Q16_W-1:0]        base_q;
	logic signed [35:0]      prod_q;
	logic [33:0]             sw_q;
	logic signed [24:0]      al_q, ar_q;
	logic signed [42:0]      mid_q;
	logic signed [41:0]      dl_q, dr_q;
	logic signed [42:0]      pl_hi_q, pl_lo_q, pr_hi_q, pr_lo_q;
	wlgm_out_t               out_q;

	// Combinational signals.
	logic                    in_acc;
	logic                    out_load;
	logic [PD_W-1:0]         pd;
	logic [TBL_AW-1:0]       i0;
	logic [TBL_AW-1:0]       i1;
	logic                    tbl_we;
	logic [TBL_AW-1:0]       tbl_raddr;
	logic [Q16_W-1:0]        tbl_rdata;
	logic signed [37:0]      rnd_sum;
	logic [Q16_W-1:0]        blend_res;
	logic [Q16_W-1:0]        neutral;
	logic [Q16_W-1:0]        wave_v;
	logic signed [17:0]      tab_diff;
	logic signed [17:0]      dep_diff;
	logic signed [17:0]      gl_diff;
	logic signed [24:0]      lr_sum, lr_diff;

	assign items.ready   = (state_q == ST_IDLE);
	assign in_acc        = items.valid && items.ready;
	assign out_load      = (state_q == ST_MIX3) && (!out_valid_q || results.ready);
	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	// Table position: integer part addresses the entry, the next 16 bits weight it.
	always_comb begin
		pd = PD_W'(pos_q) * PD_W'(TABLE_DEPTH);
		i0 = pd[PD_W-1:PHASE_W];
		i1 = (i0 == TBL_AW'(TABLE_DEPTH - 1)) ? '0 : i0 + TBL_AW'(1);
	end

	// Table writes happen only in the idle state, so they never meet a read
	// of the same item; no forwarding is needed.
	assign tbl_we    = in_acc && (items.data.operation == OP_WRITE)
		&& (32'(items.data.table_index) < 32'(TABLE_DEPTH));
	assign tbl_raddr = (state_q == ST_RD1) ? i1_q : i0;

	wlgm_ram #(.WIDTH(Q16_W), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (TBL_AW'(items.data.table_index)),
		.wdata (clamp_one(items.data.table_value)),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// Rounding of the blend a + (b - a) * w, shared by the three blends.
	always_comb begin
		rnd_sum   = $signed({5'b0, base_q, 16'b0}) + $signed({{2{prod_q[35]}}, prod_q})
			+ 38'sd32768;
		blend_res = rnd_sum[32:16];
		neutral   = mod_target_q ? HALF_Q16 : ONE_Q16;
		wave_v    = invert_q ? (ONE_Q16 - blend_res) : blend_res;
		tab_diff  = $signed({1'b0, tbl_rdata}) - $signed({1'b0, t0_q});
		dep_diff  = $signed({1'b0, wave_v}) - $signed({1'b0, neutral});
		gl_diff   = $signed({1'b0, smoothed_q}) - $signed({1'b0, blend_res});
		lr_sum    = $signed({l_q[SMP_W-1], l_q}) + $signed({r_q[SMP_W-1], r_q});
		lr_diff   = $signed({l_q[SMP_W-1], l_q}) - $signed({r_q[SMP_W-1], r_q});
	end

	// Sequencer, oscillator state, configuration and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			mod_target_q   <= 1'b0;
			phase_step_q   <= RST_PHASE_STEP;
			phase_offset_q <= '0;
			mod_depth_q    <= ONE_Q16;
			invert_q       <= 1'b0;
			glide_q        <= RST_GLIDE_COEFF;
			wet_q          <= ONE_Q16;
			dry_q          <= '0;
			phase_q        <= '0;
			smoothed_q     <= ONE_Q16;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MOD_TARGET: begin
						mod_target_q <= cfg_wdata[0];
						smoothed_q   <= cfg_wdata[0] ? HALF_Q16 : ONE_Q16;
					end
					REG_PHASE_STEP:   phase_step_q   <= cfg_wdata;
					REG_PHASE_OFFSET: phase_offset_q <= cfg_wdata;
					REG_MOD_DEPTH:    mod_depth_q    <= clamp_one(cfg_wdata[Q16_W-1:0]);
					REG_INVERT_WAVE:  invert_q       <= cfg_wdata[0];
					REG_GLIDE_COEFF:  glide_q        <= cfg_wdata[15:0];
					REG_WET_GAIN:     wet_q          <= clamp_one(cfg_wdata[Q16_W-1:0]);
					REG_DRY_GAIN:     dry_q          <= clamp_one(cfg_wdata[Q16_W-1:0]);
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && items.data.operation == OP_PROCESS) begin
						phase_q <= phase_q + phase_step_q;
						state_q <= ST_ADDR;
					end else if (in_acc && items.data.operation == OP_SET_PHASE) begin
						phase_q <= items.data.phase_value;
					end
				end
				ST_ADDR:   state_q <= ST_RD1;
				ST_RD1:    state_q <= ST_INTERP;
				ST_INTERP: state_q <= ST_DEPTH;
				ST_DEPTH:  state_q <= ST_GLIDE;
				ST_GLIDE:  state_q <= ST_MIX1;
				ST_MIX1: begin
					smoothed_q <= blend_res;
					state_q    <= ST_MIX2;
				end
				ST_MIX2: state_q <= ST_MIX3;
				ST_MIX3: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: one multiplication per blend step, its rounding in the step after; the mixing steps do several.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			l_q   <= items.data.left_in;
			r_q   <= items.data.right_in;
			pos_q <= phase_q + phase_offset_q;
		end
		unique case (state_q)
			ST_ADDR: begin
				i1_q   <= i1;
				frac_q <= pd[PHASE_W-1:16];
			end
			ST_RD1: t0_q <= tbl_rdata;
			ST_INTERP: begin
				base_q <= t0_q;
				prod_q <= tab_diff * $signed({2'b0, frac_q});
			end
			ST_DEPTH: begin
				base_q <= neutral;
				prod_q <= dep_diff * $signed({1'b0, mod_depth_q});
			end
			ST_GLIDE: begin
				base_q <= blend_res;
				prod_q <= gl_diff * $signed({2'b0, glide_q});
			end
			ST_MIX1: begin
				sw_q  <= blend_res * wet_q;
				al_q  <= mod_target_q ? lr_diff : $signed({l_q[SMP_W-1], l_q});
				ar_q  <= mod_target_q ? -lr_diff : $signed({r_q[SMP_W-1], r_q});
				mid_q <= lr_sum * $signed({1'b0, wet_q});
				dl_q  <= l_q * $signed({1'b0, dry_q});
				dr_q  <= r_q * $signed({1'b0, dry_q});
			end
			ST_MIX2: begin
				pl_hi_q <= al_q * $signed({1'b0, sw_q[33:17]});
				pl_lo_q <= al_q * $signed({1'b0, sw_q[16:0]});
				pr_hi_q <= ar_q * $signed({1'b0, sw_q[33:17]});
				pr_lo_q <= ar_q * $signed({1'b0, sw_q[16:0]});
			end
			default: ;
		endcase
		if (out_load) begin
			out_q.left_out  <= mix_lane(pl_hi_q, pl_lo_q, mid_q, dl_q, mod_target_q);
			out_q.right_out <= mix_lane(pr_hi_q, pr_lo_q, mid_q, dr_q, mod_target_q);
			out_q.mod_value <= smoothed_q;
			out_q.phase_out <= phase_q;
		end
	end

endmodule

// File: hdl/wlgm_checker.sv
`include "wavetable_lfo_gain_modulator_core_assert.svh"

// Port-level checks of the modulator core.
module wlgm_checker import wlgm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] in_op,
	input logic       out_valid,
	input logic       out_ready,
	input wlgm_out_t  out_data
);

	// A waiting result stays offered and unchanged.
	`WLGM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`WLGM_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "result changed while stalled")

	// A process item keeps the block busy in the following cycle.
	`WLGM_ASSERT(a_busy_after_process, in_valid && in_ready && in_op == OP_PROCESS |=> !in_ready, "item taken during processing")

	// The smoothed value of an offered result never exceeds one.
	`WLGM_ASSERT(a_mod_range, out_valid |-> out_data.mod_value <= ONE_Q16, "mod_value above one")

	// No result is offered while in reset.
	`WLGM_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind wavetable_lfo_gain_modulator_core wlgm_checker u_wlgm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.in_op     (items.data.operation),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.data)
);
